>>> rtl/core/gnq_pkg.sv
// Package for the gamepad navigation event qualifier.
// Holds the item structs, the per-controller state row and the register indexes.
// No dependencies.
`default_nettype none

package gnq_pkg;

   localparam int unsigned NUM_CONTROLLERS_DEF = 4;
   localparam int unsigned CSR_IDX_W           = 2;
   localparam int unsigned CSR_DATA_W          = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_THRESHOLD = 2'd1;

   localparam logic [15:0] REPEAT_DELAY_RST    = 16'd350;
   localparam logic [15:0] STICK_THRESHOLD_RST = 16'd29490;

   localparam logic signed [15:0] STICK_MAX = 16'sh7FFF;
   localparam logic signed [15:0] STICK_MIN = 16'sh8000;

   typedef struct packed {
      logic [1:0]         controller_id;
      logic               gamepad_present;
      logic [31:0]        time_ms;
      logic [3:0]         dpad_held;
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic [7:0]         a_duration;
      logic [7:0]         b_duration;
      logic [7:0]         x_duration;
      logic [7:0]         y_duration;
      logic [7:0]         start_duration;
      logic [7:0]         back_duration;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_controller;
      logic [3:0]         nav_events;
      logic               accept_event;
      logic               back_event;
      logic               create_event;
      logic               delete_event;
      logic signed [15:0] stick_x_out;
      logic signed [15:0] stick_y_out;
   } rsp_type;

   // One memory row per controller. Direction order: up, down, left, right.
   typedef struct packed {
      logic [3:0][31:0]   dpad_time;
      logic [31:0]        stick_time;
      logic signed [15:0] latch_x;
      logic signed [15:0] latch_y;
   } row_type;

   localparam int unsigned ROW_W = $bits(row_type);

   // Absolute value of a 16-bit axis; -32768 gives 32768.
   function automatic logic [16:0] axis_mag(input logic signed [15:0] v);
      logic signed [16:0] e;
      e = {v[15], v};
      return v[15] ? 17'(-e) : 17'(e);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/gamepad_nav_event_qualifier_core.sv
// Gamepad navigation event qualifier, top level.
// Uses gnq_pkg and the gnq_ram state memory.
//
// Usage:
// Each input item is one poll of one controller. The block answers every poll
// with exactly one result item: d-pad and stick directions that fired, the
// button events, and the stick values as written back.
// rsp_valid rises once the item has passed the compute stage register into the
// output register; one item is taken every cycle while req_stall is low.
// Per-controller state lives in one memory row that is read when the
// item is accepted and written back when the item moves into the output
// register. A write to the row the next item reads is forwarded.
// When rsp_stall is high the output register holds, the item in the compute
// stage waits, and req_stall rises only once that stage is occupied as well.
// Reset clears the row valid bits, so every row reads as zero until written;
// no clearing pass is needed. Registers return to their defaults.
// Configuration writes are always ready and must only happen while idle.
`default_nettype none

module gamepad_nav_event_qualifier_core
   import gnq_pkg::*;
#(
   parameter int unsigned NUM_CONTROLLERS = NUM_CONTROLLERS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

   logic [15:0]          repeat_delay_ff, repeat_delay_in;
   logic [15:0]          threshold_ff, threshold_in;
   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   logic                 s1_fwd_ff, s1_row_valid_ff;
   row_type              fwd_row_ff;
   logic                 out_full_ff, out_full_in;
   rsp_type              out_ff;
   logic [NUM_CONTROLLERS-1:0] row_valid_ff, row_valid_in;

   logic                 accept, s1_adv;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 wr_en;
   logic [ROW_W-1:0]     rd_data;
   row_type              cur_row, new_row;
   rsp_type              result;
   logic                 active;

   assign csr_ready = 1'b1;
   assign rsp_valid = out_full_ff;
   assign rsp_item  = out_ff;

   assign s1_adv    = s1_valid_ff && (!out_full_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   assign rd_addr = AW'(32'(req_item.controller_id));
   assign wr_addr = AW'(32'(s1_req_ff.controller_id));
   assign active  = s1_req_ff.gamepad_present
                    && (32'(s1_req_ff.controller_id) < NUM_CONTROLLERS);
   assign wr_en   = s1_adv && active;

   gnq_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_CONTROLLERS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (new_row),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A row never written reads as zero; a row written in the cycle it was read
   // comes from the forward register instead of the stale memory output.
   always_comb begin
      if (s1_fwd_ff) begin
         cur_row = fwd_row_ff;
      end else if (s1_row_valid_ff) begin
         cur_row = row_type'(rd_data);
      end else begin
         cur_row = '0;
      end
   end

   always_comb begin
      logic [31:0]        now;
      logic [31:0]        delay;
      logic [16:0]        thr, mag_x, mag_y;
      logic               xd, yd, xc, yc, fire;
      logic [3:0]         dirs;
      logic signed [15:0] nx, ny;

      now     = s1_req_ff.time_ms;
      delay   = {16'd0, repeat_delay_ff};
      thr     = {1'b0, threshold_ff};
      dirs    = '0;
      new_row = cur_row;

      for (int d = 0; d < 4; d++) begin
         if (s1_req_ff.dpad_held[d]) begin
            if ((now - cur_row.dpad_time[d]) >= delay) begin
               dirs[d]              = 1'b1;
               new_row.dpad_time[d] = now;
            end
         end else begin
            new_row.dpad_time[d] = '0;
         end
      end

      mag_x = axis_mag(s1_req_ff.stick_x);
      mag_y = axis_mag(s1_req_ff.stick_y);
      xd    = mag_x >= thr;
      yd    = mag_y >= thr;
      xc    = axis_mag(cur_row.latch_x) < thr;
      yc    = axis_mag(cur_row.latch_y) < thr;
      fire  = (xd || yd) && ((now - cur_row.stick_time) >= delay)
              && ((xd && xc) || (yd && yc));

      nx = s1_req_ff.stick_x;
      ny = s1_req_ff.stick_y;
      if (fire && xd) begin
         if (s1_req_ff.stick_x[15]) begin
            nx      = STICK_MIN;
            dirs[2] = 1'b1;
         end else begin
            nx      = STICK_MAX;
            dirs[3] = 1'b1;
         end
      end
      if (fire && yd) begin
         if (s1_req_ff.stick_y[15]) begin
            ny      = STICK_MIN;
            dirs[1] = 1'b1;
         end else begin
            ny      = STICK_MAX;
            dirs[0] = 1'b1;
         end
      end

      if (fire) begin
         new_row.stick_time = now;
         new_row.latch_x    = nx;
         new_row.latch_y    = ny;
      end else begin
         new_row.latch_x = '0;
         new_row.latch_y = '0;
      end

      result.result_controller = s1_req_ff.controller_id;
      if (active) begin
         result.nav_events   = {dirs[1], dirs[0], dirs[3], dirs[2]};
         result.accept_event = (s1_req_ff.a_duration == 8'd1)
                               || (s1_req_ff.start_duration == 8'd1);
         result.back_event   = (s1_req_ff.b_duration == 8'd1)
                               || (s1_req_ff.back_duration == 8'd1);
         result.create_event = s1_req_ff.y_duration == 8'd1;
         result.delete_event = s1_req_ff.x_duration == 8'd1;
         result.stick_x_out  = nx;
         result.stick_y_out  = ny;
      end else begin
         result.nav_events   = '0;
         result.accept_event = 1'b0;
         result.back_event   = 1'b0;
         result.create_event = 1'b0;
         result.delete_event = 1'b0;
         result.stick_x_out  = s1_req_ff.stick_x;
         result.stick_y_out  = s1_req_ff.stick_y;
      end
   end

   always_comb begin
      repeat_delay_in = repeat_delay_ff;
      threshold_in    = threshold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REPEAT_DELAY:    repeat_delay_in = csr_wdata;
            CSR_STICK_THRESHOLD: threshold_in    = csr_wdata;
            default:             ;
         endcase
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv) begin
         out_full_in = 1'b1;
      end else if (!rsp_stall) begin
         out_full_in = 1'b0;
      end else begin
         out_full_in = out_full_ff;
      end

      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff <= REPEAT_DELAY_RST;
         threshold_ff    <= STICK_THRESHOLD_RST;
         s1_valid_ff     <= 1'b0;
         out_full_ff     <= 1'b0;
         row_valid_ff    <= '0;
      end else begin
         repeat_delay_ff <= repeat_delay_in;
         threshold_ff    <= threshold_in;
         s1_valid_ff     <= s1_valid_in;
         out_full_ff     <= out_full_in;
         row_valid_ff    <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff       <= req_item;
         s1_fwd_ff       <= wr_en && (wr_addr == rd_addr);
         s1_row_valid_ff <= row_valid_ff[rd_addr];
      end
      if (wr_en) begin
         fwd_row_ff <= new_row;
      end
      if (s1_adv) begin
         out_ff <= result;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/gnq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module gnq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
